// ===== sv/text_console_writer_assert.svh =====
// ----------------------------------------------------------------------------
// text_console_writer_assert
// Assertion helpers for the console writer RTL.
// ----------------------------------------------------------------------------
// Both forms sample on clk_i and stay quiet while rst_ni is low.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication.
`define TCW_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCW_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and types of the text console writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  localparam int unsigned POS_W  = 11;
  localparam int unsigned CELL_W = 16;

  localparam logic [7:0] ATTR_RESET     = 8'h07;
  localparam logic [7:0] CHAR_BLANK     = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [7:0] CHAR_RETURN    = 8'd13;

  typedef enum logic [2:0] {
    KIND_WRITE = 3'd0,
    KIND_CLEAR = 3'd1,
    KIND_LEFT  = 3'd2,
    KIND_RIGHT = 3'd3,
    KIND_READ  = 3'd4
  } kind_e;

  // Port strobes from the sequencer to the screen memory.
  typedef struct packed {
    logic we;
    logic re;
  } tcw_mem_ctl_t;

endpackage

`default_nettype wire

// ===== sv/tcw_screen_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Screen cell memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_screen_ram
  import tcw_pkg::*;
#(
  parameter int unsigned DEPTH = COLUMNS_DEF * ROWS_DEF,
  parameter int unsigned AW    = $clog2(COLUMNS_DEF * ROWS_DEF)
) (
  input  wire logic                clk_i,
  input  wire tcw_mem_ctl_t        ctl_i,
  input  wire logic [AW-1:0]       waddr_i,
  input  wire logic [CELL_W-1:0]   wdata_i,
  input  wire logic [AW-1:0]       raddr_i,
  output logic      [CELL_W-1:0]   rdata_o
);

  logic [CELL_W-1:0] mem_q [DEPTH];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// Cursor state and memory sequencer: single-cell writes, reads, screen
// sweeps for reset and clear, and the row-up copy of a scroll.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS = COLUMNS_DEF,
  parameter int unsigned ROWS    = ROWS_DEF,
  parameter int unsigned AW      = $clog2(COLUMNS_DEF * ROWS_DEF)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [2:0]         kind_i,
  input  wire logic [7:0]         char_code_i,
  input  wire logic [10:0]        cell_index_i,
  input  wire logic [7:0]         attr_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic [POS_W-1:0]        cursor_position_o,
  output logic [CELL_W-1:0]       cell_data_o,
  output tcw_mem_ctl_t            mem_ctl_o,
  output logic [AW-1:0]           mem_waddr_o,
  output logic [CELL_W-1:0]       mem_wdata_o,
  output logic [AW-1:0]           mem_raddr_o,
  input  wire logic [CELL_W-1:0]  mem_rdata_i
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned CLW   = $clog2(COLUMNS + 1);
  localparam int unsigned RW    = $clog2(ROWS);

  localparam logic [CLW-1:0] COL_FULL    = CLW'(COLUMNS);
  localparam logic [CLW-1:0] COL_LAST    = CLW'(COLUMNS - 1);
  localparam logic [RW-1:0]  ROW_LAST    = RW'(ROWS - 1);
  localparam logic [AW-1:0]  CELL_LAST   = AW'(CELLS - 1);
  localparam logic [AW-1:0]  COPY_FIRST  = AW'(COLUMNS);
  localparam logic [AW-1:0]  BLANK_FIRST = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0]  ROW_STRIDE  = AW'(COLUMNS);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_COPY,
    ST_DRAIN,
    ST_BLANK
  } state_e;

  state_e             state_q;
  logic [CLW-1:0]     col_q;
  logic [RW-1:0]      row_q;
  logic [AW-1:0]      cnt_q;
  logic               cp_v_q;
  logic [AW-1:0]      cp_wa_q;
  logic               pend_q;
  logic [7:0]         pch_q;
  logic               rd_ok_q;
  logic               done_q;
  logic [CELL_W-1:0]  data_q;

  logic               accept;
  logic [CLW-1:0]     nxt_col;
  logic [RW-1:0]      nxt_row;
  logic               st_wr;
  logic [CLW-1:0]     st_col;
  logic [RW-1:0]      st_row;
  logic [7:0]         st_char;
  logic               go_scroll;
  logic               go_pend;
  logic               go_clear;
  logic               go_read;
  logic               rd_ok;
  logic [31:0]        st_addr_wide;
  logic [31:0]        pos_wide;
  logic [31:0]        cell_wide;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // Decode one item against the current cursor.
  always_comb begin
    nxt_col   = col_q;
    nxt_row   = row_q;
    st_wr     = 1'b0;
    st_col    = col_q;
    st_row    = row_q;
    st_char   = char_code_i;
    go_scroll = 1'b0;
    go_pend   = 1'b0;
    go_clear  = 1'b0;
    go_read   = 1'b0;
    case (kind_e'(kind_i))
      KIND_WRITE: begin
        if (char_code_i == CHAR_NEWLINE) begin
          nxt_col = '0;
          if (row_q == ROW_LAST) begin
            go_scroll = 1'b1;
          end else begin
            nxt_row = row_q + RW'(1);
          end
        end else if (char_code_i == CHAR_BACKSPACE) begin
          if (col_q != '0) begin
            nxt_col = col_q - CLW'(1);
          end else if (row_q != '0) begin
            nxt_row = row_q - RW'(1);
            nxt_col = COL_LAST;
          end
          st_wr   = 1'b1;
          st_col  = nxt_col;
          st_row  = nxt_row;
          st_char = CHAR_BLANK;
        end else if (char_code_i == CHAR_RETURN) begin
          nxt_col = '0;
        end else if (col_q >= COL_FULL) begin
          nxt_col = CLW'(1);
          if (row_q == ROW_LAST) begin
            go_scroll = 1'b1;
            go_pend   = 1'b1;
          end else begin
            nxt_row = row_q + RW'(1);
            st_wr   = 1'b1;
            st_col  = '0;
            st_row  = nxt_row;
          end
        end else begin
          st_wr   = 1'b1;
          nxt_col = col_q + CLW'(1);
        end
      end
      KIND_CLEAR: begin
        nxt_col  = '0;
        nxt_row  = '0;
        go_clear = 1'b1;
      end
      KIND_LEFT: begin
        if (col_q != '0) begin
          nxt_col = col_q - CLW'(1);
        end
      end
      KIND_RIGHT: begin
        if (col_q < COL_LAST) begin
          nxt_col = col_q + CLW'(1);
        end
      end
      KIND_READ: begin
        go_read = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign st_addr_wide = 32'(st_row) * 32'(COLUMNS) + 32'(st_col);
  assign cell_wide    = 32'(cell_index_i);
  assign rd_ok        = (cell_wide < 32'(CELLS));

  // Memory port steering.
  always_comb begin
    mem_ctl_o   = '0;
    mem_waddr_o = cnt_q;
    mem_wdata_o = {attr_i, CHAR_BLANK};
    mem_raddr_o = cnt_q;
    case (state_q)
      ST_INIT: begin
        mem_ctl_o.we = 1'b1;
        mem_wdata_o  = {ATTR_RESET, CHAR_BLANK};
      end
      ST_IDLE: begin
        if (accept && st_wr) begin
          mem_ctl_o.we = 1'b1;
          mem_waddr_o  = st_addr_wide[AW-1:0];
          mem_wdata_o  = {attr_i, st_char};
        end
        if (accept && go_read) begin
          mem_ctl_o.re = 1'b1;
          mem_raddr_o  = rd_ok ? cell_wide[AW-1:0] : '0;
        end
      end
      ST_CLEAR: begin
        mem_ctl_o.we = 1'b1;
      end
      ST_COPY, ST_DRAIN: begin
        mem_ctl_o.re = (state_q == ST_COPY);
        if (cp_v_q) begin
          mem_ctl_o.we = 1'b1;
          mem_waddr_o  = cp_wa_q;
          mem_wdata_o  = mem_rdata_i;
        end
      end
      ST_BLANK: begin
        mem_ctl_o.we = 1'b1;
        if (pend_q && (cnt_q == BLANK_FIRST)) begin
          mem_wdata_o = {attr_i, pch_q};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      col_q   <= '0;
      row_q   <= '0;
      cnt_q   <= '0;
      cp_v_q  <= 1'b0;
      cp_wa_q <= '0;
      pend_q  <= 1'b0;
      pch_q   <= '0;
      rd_ok_q <= 1'b0;
      done_q  <= 1'b0;
      data_q  <= '0;
    end else begin
      done_q <= 1'b0;
      cp_v_q <= 1'b0;
      case (state_q)
        ST_INIT: begin
          cnt_q <= cnt_q + AW'(1);
          if (cnt_q == CELL_LAST) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            col_q <= nxt_col;
            row_q <= nxt_row;
            if (go_clear) begin
              cnt_q   <= '0;
              state_q <= ST_CLEAR;
            end else if (go_scroll) begin
              cnt_q   <= COPY_FIRST;
              pend_q  <= go_pend;
              pch_q   <= char_code_i;
              state_q <= ST_COPY;
            end else if (go_read) begin
              rd_ok_q <= rd_ok;
              state_q <= ST_READ;
            end else begin
              done_q <= 1'b1;
              data_q <= '0;
            end
          end
        end
        ST_CLEAR: begin
          cnt_q <= cnt_q + AW'(1);
          if (cnt_q == CELL_LAST) begin
            done_q  <= 1'b1;
            data_q  <= '0;
            state_q <= ST_IDLE;
          end
        end
        ST_READ: begin
          done_q  <= 1'b1;
          data_q  <= rd_ok_q ? mem_rdata_i : '0;
          state_q <= ST_IDLE;
        end
        ST_COPY: begin
          cp_v_q  <= 1'b1;
          cp_wa_q <= cnt_q - ROW_STRIDE;
          cnt_q   <= cnt_q + AW'(1);
          if (cnt_q == CELL_LAST) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          cnt_q   <= BLANK_FIRST;
          state_q <= ST_BLANK;
        end
        ST_BLANK: begin
          cnt_q <= cnt_q + AW'(1);
          if (cnt_q == CELL_LAST) begin
            pend_q  <= 1'b0;
            done_q  <= 1'b1;
            data_q  <= '0;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign pos_wide          = 32'(row_q) * 32'(COLUMNS) + 32'(col_q);
  assign cursor_position_o = pos_wide[POS_W-1:0];
  assign done_o            = done_q;
  assign cell_data_o       = data_q;

endmodule

`default_nettype wire

// ===== sv/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine: screen cell memory, cursor and command sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a command by raising start with kind_i, char_code_i and cell_index_i;
//   it is taken at a clock edge where start is high and busy is low.
//   Every command returns exactly one word: done_o pulses for one cycle with
//   cursor_position_o and cell_data_o valid. The receiver cannot stall.
//   Command flow, set by the screen memory sweeps:
//   - plain writes, controls, cursor moves: word in the cycle after accept,
//     next command taken the very next cycle (one command per cycle);
//   - read cell: one memory read, then the registered data;
//   - clear screen: one cell written per cycle, then the word;
//   - scroll (newline or wrap on the bottom row): a copy of each row one
//     row up, a drain step and the blanking of the bottom row, then the word.
//   After reset busy stays high while the memory is filled with blanks of
//   attribute 7. The attribute register may be written at any time through
//   attr_we_i / attr_wdata_i, but only between commands does it take effect
//   consistently.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS = COLUMNS_DEF,
  parameter int unsigned ROWS    = ROWS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         kind_i,
  input  wire logic [7:0]         char_code_i,
  input  wire logic [10:0]        cell_index_i,
  input  wire logic               attr_we_i,
  input  wire logic [7:0]         attr_wdata_i,
  output logic                    done_o,
  output logic [POS_W-1:0]        cursor_position_o,
  output logic [CELL_W-1:0]       cell_data_o
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);

  // Attribute byte applied to every new character and to cells blanked by clear, scroll or backspace.
  logic [7:0] attr_q;

  tcw_mem_ctl_t      mem_ctl;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  // Hold the attribute; load it on a configuration write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (attr_we_i) begin
      attr_q <= attr_wdata_i;
    end
  end

  // Sequencer: decodes commands, owns the cursor, drives both memory ports.
  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start),
    .kind_i            (kind_i),
    .char_code_i       (char_code_i),
    .cell_index_i      (cell_index_i),
    .attr_i            (attr_q),
    .busy_o            (busy),
    .done_o            (done_o),
    .cursor_position_o (cursor_position_o),
    .cell_data_o       (cell_data_o),
    .mem_ctl_o         (mem_ctl),
    .mem_waddr_o       (mem_waddr),
    .mem_wdata_o       (mem_wdata),
    .mem_raddr_o       (mem_raddr),
    .mem_rdata_i       (mem_rdata)
  );

  // Screen cells, one per character position.
  tcw_screen_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

`include "text_console_writer_assert.svh"

  // A result word only ever leaves from the idle state.
  `TCW_ASSERT_IMPLY(a_done_idle, done_o, !busy, "result word while busy")
  // A read command occupies the memory read cycle before its word.
  `TCW_ASSERT_NEXT(a_read_busy, start && !busy && kind_i == KIND_READ, busy && !done_o, "read skipped memory cycle")
  // Every memory write lands inside the screen.
  `TCW_ASSERT_IMPLY(a_wr_range, mem_ctl.we, mem_waddr <= AW'(CELLS - 1), "write outside screen")

endmodule

`default_nettype wire

// ===== tb/text_console_writer_test.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_test
// Self-checking bench for the text console writer. A queue of commands feeds
// a clocked driver, and a clocked monitor compares each returned word with
// the word that a local screen and cursor model predicts. The run starts
// with a short directed list at the reset attribute, then goes through
// random phases, each at its own attribute value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_writer_test;
  import tcw_pkg::*;

  localparam int unsigned COLS  = COLUMNS_DEF;
  localparam int unsigned LINES = ROWS_DEF;
  localparam int unsigned CELLS = COLS * LINES;

  // Kind codes that the block leaves without effect.
  localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

  // A clear or a scroll keeps the block busy for a sweep of the screen, and
  // the fill after reset as long again. Allow many times that with no handshake.
  localparam int unsigned QUIET_LIMIT  = 20 * CELLS;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned PHASE_ITEMS  = 210;
  // Window of accepted commands in which the driver inserts no random holds.
  localparam int unsigned CALM_FROM = 350;
  localparam int unsigned CALM_TO   = 560;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } console_cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_position;
    logic [CELL_W-1:0] cell_data;
  } console_word_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              start        = 1'b0;
  logic              busy;
  logic [2:0]        kind_i       = KIND_WRITE;
  logic [7:0]        char_code_i  = '0;
  logic [10:0]       cell_index_i = '0;
  logic              attr_we_i    = 1'b0;
  logic [7:0]        attr_wdata_i = '0;
  logic              done_o;
  logic [POS_W-1:0]  cursor_position_o;
  logic [CELL_W-1:0] cell_data_o;

  text_console_writer i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .kind_i            (kind_i),
    .char_code_i       (char_code_i),
    .cell_index_i      (cell_index_i),
    .attr_we_i         (attr_we_i),
    .attr_wdata_i      (attr_wdata_i),
    .done_o            (done_o),
    .cursor_position_o (cursor_position_o),
    .cell_data_o       (cell_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Screen model: our own copy of the cells, cursor and attribute register.
  // --------------------------------------------------------------------------
  logic [15:0] screen_model [CELLS];
  int unsigned col_model;
  int unsigned row_model;
  logic [7:0]  attr_model;

  console_cmd_t  pending_cmds [$];
  console_word_t expected_words [$];
  console_cmd_t  cur_cmd;
  int unsigned   taken_count    = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   quiet_cycles   = 0;

  function automatic void blank_screen_model();
    for (int unsigned i = 0; i < CELLS; i++) screen_model[i] = {attr_model, CHAR_BLANK};
  endfunction

  // Drop to column 0 of the next row; past the bottom, shift every row up
  // and bring in a blank bottom row at the current attribute.
  function automatic void advance_line_model();
    col_model = 0;
    row_model++;
    if (row_model >= LINES) begin
      for (int unsigned i = 0; i < (LINES - 1) * COLS; i++) screen_model[i] = screen_model[i + COLS];
      for (int unsigned i = (LINES - 1) * COLS; i < CELLS; i++) begin
        screen_model[i] = {attr_model, CHAR_BLANK};
      end
      row_model = LINES - 1;
    end
  endfunction

  // Advance the model by one command and return the word it must produce.
  function automatic console_word_t apply_console_cmd(console_cmd_t cmd);
    console_word_t w;
    w.cell_data = '0;
    case (cmd.kind)
      KIND_WRITE: begin
        if (cmd.char_code == CHAR_NEWLINE) begin
          advance_line_model();
        end else if (cmd.char_code == CHAR_BACKSPACE) begin
          // Step back, wrapping to the last column of the row above; the
          // top-left corner holds. The cell under the cursor is blanked.
          if (col_model > 0) begin
            col_model--;
          end else if (row_model > 0) begin
            row_model--;
            col_model = COLS - 1;
          end
          screen_model[row_model * COLS + col_model] = {attr_model, CHAR_BLANK};
        end else if (cmd.char_code == CHAR_RETURN) begin
          col_model = 0;
        end else begin
          // A full row wraps (and maybe scrolls) before the store.
          if (col_model >= COLS) advance_line_model();
          screen_model[row_model * COLS + col_model] = {attr_model, cmd.char_code};
          col_model++;
        end
      end
      KIND_CLEAR: begin
        blank_screen_model();
        col_model = 0;
        row_model = 0;
      end
      KIND_LEFT: begin
        if (col_model > 0) col_model--;
      end
      KIND_RIGHT: begin
        if (col_model < COLS - 1) col_model++;
      end
      KIND_READ: begin
        if (cmd.cell_index < CELLS) w.cell_data = screen_model[cmd.cell_index];
      end
      default: begin
      end
    endcase
    w.cursor_position = POS_W'(row_model * COLS + col_model);
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present the next pending command when the slot is free and no random
  // hold is drawn; keep it while busy is high. The model advances on the accepting edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic hold;
    hold = !(taken_count >= CALM_FROM && taken_count < CALM_TO) &&
           ($urandom_range(0, 99) < 10);
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_words.push_back(apply_console_cmd(cur_cmd));
        taken_count++;
      end
      if (!start || !busy) begin
        if (pending_cmds.size() != 0 && !hold) begin
          cur_cmd = pending_cmds.pop_front();
          kind_i       <= cur_cmd.kind;
          char_code_i  <= cur_cmd.char_code;
          cell_index_i <= cur_cmd.cell_index;
          start        <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch: %s got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Monitor: every done pulse is one word; match it against the oldest
  // prediction, field by field.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    console_word_t want;
    if (rst_ni && done_o) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word, position", cursor_position_o, 0);
      end else begin
        want = expected_words.pop_front();
        if (cursor_position_o !== want.cursor_position) begin
          report_mismatch("cursor_position", cursor_position_o, want.cursor_position);
        end
        if (cell_data_o !== want.cell_data) begin
          report_mismatch("cell_data", cell_data_o, want.cell_data);
        end
      end
    end
  end

  // Watchdog: end the run if no command and no word moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void push_cmd(logic [2:0] kind, logic [7:0] ch, logic [10:0] idx);
    console_cmd_t c;
    c.kind       = kind;
    c.char_code  = ch;
    c.cell_index = idx;
    pending_cmds.push_back(c);
  endfunction

  function automatic logic [10:0] any_index();
    return 11'($urandom_range(0, 2047));
  endfunction

  // Wait, sampling at the falling edge so every driver update has settled,
  // until nothing is queued, presented, expected or in progress.
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_cmds.size() != 0 || start || expected_words.size() != 0 || busy !== 1'b0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_attribute(logic [7:0] value);
    @(posedge clk_i);
    attr_we_i    <= 1'b1;
    attr_wdata_i <= value;
    @(posedge clk_i);
    attr_we_i    <= 1'b0;
    attr_wdata_i <= ~value;
    attr_model = value;
    @(negedge clk_i);
  endtask

  // Random phase made of short well-formed runs: text lines that may wrap,
  // newline bursts that reach the bottom and scroll, backspace runs, cursor
  // walks and reads, with a little noise and an occasional clear.
  task automatic load_random(int unsigned count);
    int unsigned n;
    int unsigned pick;
    int unsigned len;
    logic [2:0]  walk;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(70, 95) : $urandom_range(1, 30);
        for (int unsigned i = 0; i < len; i++) begin
          push_cmd(KIND_WRITE, 8'($urandom_range(0, 255)), any_index());
        end
        if ($urandom_range(0, 1) == 0) begin
          push_cmd(KIND_WRITE, CHAR_NEWLINE, any_index());
          len++;
        end
        n += len;
      end else if (pick < 55) begin
        len = $urandom_range(1, 6);
        for (int unsigned i = 0; i < len; i++) push_cmd(KIND_WRITE, CHAR_NEWLINE, any_index());
        n += len;
      end else if (pick < 65) begin
        len = $urandom_range(1, 5);
        for (int unsigned i = 0; i < len; i++) push_cmd(KIND_WRITE, CHAR_BACKSPACE, any_index());
        n += len;
      end else if (pick < 71) begin
        push_cmd(KIND_WRITE, CHAR_RETURN, any_index());
        n++;
      end else if (pick < 80) begin
        walk = ($urandom_range(0, 1) == 0) ? KIND_LEFT : KIND_RIGHT;
        len = $urandom_range(1, 40);
        for (int unsigned i = 0; i < len; i++) begin
          push_cmd(walk, 8'($urandom_range(0, 255)), any_index());
        end
        n += len;
      end else if (pick < 94) begin
        len = $urandom_range(1, 4);
        for (int unsigned i = 0; i < len; i++) begin
          // Mostly on-screen cells, sometimes past the end.
          push_cmd(KIND_READ, 8'($urandom_range(0, 255)),
                   ($urandom_range(0, 9) == 0) ? 11'($urandom_range(CELLS, 2047))
                                               : 11'($urandom_range(0, CELLS - 1)));
        end
        n += len;
      end else if (pick < 96) begin
        push_cmd(3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)),
                 8'($urandom_range(0, 255)), any_index());
        n++;
      end else if (pick < 98) begin
        push_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), any_index());
        n++;
      end else begin
        push_cmd(KIND_CLEAR, 8'($urandom_range(0, 255)), any_index());
        n++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence of the run
  // --------------------------------------------------------------------------
  initial begin
    attr_model = ATTR_RESET;
    blank_screen_model();
    col_model = 0;
    row_model = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Hold until the post-reset fill of the screen has finished.
    @(negedge clk_i);
    while (busy !== 1'b0) @(negedge clk_i);

    // Directed list at the reset attribute.
    push_cmd(KIND_READ, 8'h00, 11'd0);                  // blank after reset
    push_cmd(KIND_READ, 8'hFF, 11'(CELLS - 1));         // last cell
    push_cmd(KIND_READ, 8'h00, 11'(CELLS));             // first index off screen
    push_cmd(KIND_READ, 8'hFF, 11'h7FF);                // largest index
    push_cmd(KIND_WRITE, 8'h41, 11'h7FF);
    push_cmd(KIND_WRITE, 8'h00, 11'd0);
    push_cmd(KIND_WRITE, 8'hFF, 11'h555);
    push_cmd(KIND_READ, 8'h00, 11'd0);
    push_cmd(KIND_READ, 8'h00, 11'd1);
    push_cmd(KIND_READ, 8'h00, 11'd2);
    push_cmd(KIND_WRITE, CHAR_RETURN, 11'd0);
    push_cmd(KIND_LEFT, 8'h00, 11'd0);                  // left at column 0
    push_cmd(KIND_WRITE, CHAR_BACKSPACE, 11'd0);        // backspace at the corner
    push_cmd(KIND_READ, 8'h00, 11'd0);
    push_cmd(KIND_RIGHT, 8'hAA, 11'h2AA);
    push_cmd(KIND_RIGHT, 8'h55, 11'h555);
    push_cmd(KIND_WRITE, CHAR_NEWLINE, 11'd0);
    push_cmd(KIND_WRITE, CHAR_BACKSPACE, 11'd0);        // wrap to the row above
    push_cmd(KIND_READ, 8'h00, 11'(COLS - 1));
    push_cmd(KIND_SPARE_FIRST, 8'hFF, 11'h7FF);
    push_cmd(KIND_SPARE_LAST, 8'h5A, 11'h3C3);
    push_cmd(KIND_CLEAR, 8'h00, 11'd0);
    push_cmd(KIND_READ, 8'h00, 11'd0);
    push_cmd(KIND_WRITE, CHAR_BLANK, 11'd0);
    wait_drained();

    // Random phases, each behind a quiet point and an attribute write; the
    // extremes come first.
    for (int unsigned phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_attribute(8'h00);
        1: write_attribute(8'hFF);
        default: write_attribute(8'($urandom_range(0, 255)));
      endcase
      load_random(PHASE_ITEMS);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (expected_words.size() != 0) begin
      report_mismatch("words still expected", 0, expected_words.size());
    end
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
